[rtl/bpccc_pkg.sv]
package bpccc_pkg;

  localparam int OpW       = 2;
  localparam int LitW      = 12;
  localparam int StatusW   = 3;
  localparam int PendW     = 7;
  localparam int NumVarsW  = 11;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  localparam int MaxVarsDef   = 1024;
  localparam int SlotsDef     = 64;
  localparam int StoreLitsDef = 4096;

  localparam logic [NumVarsW-1:0] NumVarsRst = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_FORMULA = 2'd0,
    OP_CUBE    = 2'd1,
    OP_COMMIT  = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK       = 3'd0,
    STS_FAIL     = 3'd1,
    STS_RANGE    = 3'd2,
    STS_FULL     = 3'd3,
    STS_CONFLICT = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic clear;
    logic flush_end;
  } cmd_t;

  typedef struct packed {
    logic flush_go;
    logic walk_done;
    logic clr_last;
  } sts_t;

endpackage

[rtl/bit_parallel_cube_clause_checker_unit.sv]
// An accepted item is evaluated in the EXEC state, which registers its result beat; no new
// item is taken while busy. A flush (an explicit flush with cubes pending, or a commit
// that fills the last slot) adds a clause store walk over the stored literals and a
// valuation clear of all 2*MAX_VARS+1 entries, one entry at a time.
// Reset: busy stays high through a full valuation clear; APB writes still taken.
// No backpressure: each result is valid for exactly one cycle on result_valid_o.
module bit_parallel_cube_clause_checker_unit
  import bpccc_pkg::*;
#(
  parameter int MAX_VARS   = MaxVarsDef,
  parameter int SLOTS      = SlotsDef,
  parameter int STORE_LITS = StoreLitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [OpW-1:0]         opcode_i,
  input  logic signed [LitW-1:0] literal_i,
  output logic                   result_valid_o,
  output logic [StatusW-1:0]     status_o,
  output logic                   flushed_o,
  output logic [PendW-1:0]       pending_cubes_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrW-1:0]    paddr,
  input  logic [CfgDataW-1:0]    pwdata,
  output logic [CfgDataW-1:0]    prdata,
  output logic                   pready
);

  logic [NumVarsW-1:0] var_limit_q;
  logic                reg_sel;
  cmd_t                cmd;
  sts_t                sts;

  assign reg_sel = (paddr[CfgAddrW-1:2] == '0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CfgDataW'(var_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_limit_q <= NumVarsRst;
    end else if (psel && penable && pwrite && reg_sel) begin
      var_limit_q <= pwdata[NumVarsW-1:0];
    end
  end

  bpccc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  bpccc_dpath #(
    .MaxVars   (MAX_VARS),
    .Slots     (SLOTS),
    .StoreLits (STORE_LITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .literal_i       (literal_i),
    .var_limit_i     (var_limit_q),
    .status_o        (status_o),
    .flushed_o       (flushed_o),
    .pending_cubes_o (pending_cubes_o)
  );

endmodule

[rtl/bpccc_ctrl.sv]
module bpccc_ctrl
  import bpccc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic result_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_CLR
  } state_e;

  state_e state_q;
  logic   valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          if (sts_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (sts_i.flush_go) begin
            state_q <= S_WALK;
          end else begin
            state_q <= S_IDLE;
            valid_q <= 1'b1;
          end
        end
        S_WALK: begin
          if (sts_i.walk_done) state_q <= S_CLR;
        end
        S_CLR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
            valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = start && (state_q == S_IDLE);
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.walk      = (state_q == S_WALK);
    cmd_o.clear     = (state_q == S_INIT) || (state_q == S_CLR);
    cmd_o.flush_end = (state_q == S_CLR) && sts_i.clr_last;
  end

endmodule

[rtl/bpccc_dpath.sv]
module bpccc_dpath
  import bpccc_pkg::*;
#(
  parameter int MaxVars   = MaxVarsDef,
  parameter int Slots     = SlotsDef,
  parameter int StoreLits = StoreLitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic [OpW-1:0]             opcode_i,
  input  logic signed [LitW-1:0]     literal_i,
  input  logic [NumVarsW-1:0]        var_limit_i,
  output logic [StatusW-1:0]         status_o,
  output logic                       flushed_o,
  output logic [PendW-1:0]           pending_cubes_o
);

  localparam int VDepth = 2 * MaxVars + 1;
  localparam int VAW    = $clog2(VDepth);
  localparam int SAW    = $clog2(StoreLits);
  localparam int SCW    = $clog2(StoreLits + 1);
  localparam int LW     = ((VAW > LitW) ? VAW : LitW) + 1;
  localparam int MagW   = LitW + 1;

  function automatic logic [VAW-1:0] pos_addr(input logic signed [LitW-1:0] l);
    logic signed [LW-1:0] s;
    s = LW'(l) + LW'(MaxVars);
    return s[VAW-1:0];
  endfunction

  function automatic logic [VAW-1:0] neg_addr(input logic signed [LitW-1:0] l);
    logic signed [LW-1:0] s;
    s = LW'(MaxVars) - LW'(l);
    return s[VAW-1:0];
  endfunction

  logic [Slots-1:0]       vmem [VDepth];
  logic signed [LitW-1:0] smem [StoreLits];

  op_e                    op_q;
  logic signed [LitW-1:0] lit_q;
  logic [Slots-1:0]       rdata_a_q;
  logic [Slots-1:0]       rdata_b_q;
  logic signed [LitW-1:0] sdata_q;
  logic [PendW-1:0]       slot_q;
  logic [SCW-1:0]         cnt_q;
  logic [SCW-1:0]         walk_cnt_q;
  logic                   s1_v_q;
  logic                   s2_v_q;
  logic                   s2_zero_q;
  logic [Slots-1:0]       acc_q;
  logic                   fail_q;
  logic [VAW-1:0]         clr_cnt_q;
  status_e                status_q;
  logic                   flushed_q;

  logic [MagW-1:0]  mag;
  logic             in_bound;
  logic             store_full;
  logic [Slots-1:0] cur;
  logic [Slots-1:0] used;
  logic             conflict;
  logic [VAW-1:0]   addr_a;
  logic             vwr_en;
  logic [VAW-1:0]   vwr_addr;
  logic [Slots-1:0] vwr_data;
  logic             swr_en;
  logic             walk_issue;

  assign mag        = lit_q[LitW-1] ? (MagW'(0) - MagW'(lit_q)) : MagW'(lit_q);
  assign in_bound   = (mag <= MagW'(var_limit_i)) && (32'(mag) <= MaxVars);
  assign store_full = (cnt_q >= SCW'(StoreLits));
  assign cur        = Slots'(1) << slot_q;
  assign used       = ~({Slots{1'b1}} << slot_q);
  assign conflict   = |(rdata_b_q & cur);
  assign addr_a     = cmd_i.walk ? pos_addr(sdata_q) : pos_addr(literal_i);
  assign walk_issue = cmd_i.walk && (walk_cnt_q != cnt_q);

  assign sts_o.flush_go  = ((op_q == OP_COMMIT) && (7'(slot_q + 7'd1) == 7'(Slots))) ||
                           ((op_q == OP_FLUSH) && (slot_q != '0));
  assign sts_o.walk_done = (walk_cnt_q == cnt_q) && !s1_v_q && !s2_v_q;
  assign sts_o.clr_last  = (clr_cnt_q == VAW'(VDepth - 1));

  always_comb begin
    vwr_en   = 1'b0;
    vwr_addr = pos_addr(lit_q);
    vwr_data = rdata_a_q | cur;
    swr_en   = 1'b0;
    if (cmd_i.clear) begin
      vwr_en   = 1'b1;
      vwr_addr = clr_cnt_q;
      vwr_data = '0;
    end else if (cmd_i.exec) begin
      case (op_q)
        OP_FORMULA: swr_en = in_bound && !store_full;
        OP_CUBE:    vwr_en = in_bound && (lit_q != '0) && !conflict;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwr_en) vmem[vwr_addr] <= vwr_data;
    rdata_a_q <= vmem[addr_a];
    rdata_b_q <= vmem[neg_addr(literal_i)];
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) smem[cnt_q[SAW-1:0]] <= lit_q;
    sdata_q <= smem[walk_cnt_q[SAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      cnt_q      <= '0;
      walk_cnt_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= sts_o.clr_last ? '0 : clr_cnt_q + VAW'(1);
      end
      if (cmd_i.exec) begin
        walk_cnt_q <= '0;
        s1_v_q     <= 1'b0;
        s2_v_q     <= 1'b0;
        if (swr_en) cnt_q <= cnt_q + SCW'(1);
        if (op_q == OP_COMMIT) slot_q <= slot_q + 7'd1;
      end else begin
        s1_v_q <= walk_issue;
        s2_v_q <= s1_v_q;
        if (walk_issue) walk_cnt_q <= walk_cnt_q + SCW'(1);
      end
      if (cmd_i.flush_end) slot_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(opcode_i);
      lit_q <= literal_i;
    end
    s2_zero_q <= (sdata_q == '0);
    if (cmd_i.exec) begin
      acc_q     <= '0;
      fail_q    <= 1'b0;
      flushed_q <= 1'b0;
      status_q  <= STS_OK;
      case (op_q)
        OP_FORMULA: begin
          if (!in_bound)      status_q <= STS_RANGE;
          else if (store_full) status_q <= STS_FULL;
        end
        OP_CUBE: begin
          if (!in_bound)                       status_q <= STS_RANGE;
          else if ((lit_q != '0) && conflict)  status_q <= STS_CONFLICT;
        end
        default: ;
      endcase
    end else if (s2_v_q) begin
      if (s2_zero_q) begin
        if (acc_q != used) fail_q <= 1'b1;
        acc_q <= '0;
      end else begin
        acc_q <= acc_q | rdata_a_q;
      end
    end
    if (cmd_i.flush_end) begin
      status_q  <= fail_q ? STS_FAIL : STS_OK;
      flushed_q <= 1'b1;
    end
  end

  assign status_o        = status_q;
  assign flushed_o       = flushed_q;
  assign pending_cubes_o = slot_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bpccc_pkg::*;

  localparam int RANDOM_BEATS = 1000;
  localparam int CYCLE_LIMIT = 8 * (RANDOM_BEATS + 200) * (2*MaxVarsDef + StoreLitsDef + 16);
  localparam int CORE_VARS = 4;
  localparam logic [CfgAddrW-1:0] REG_VAR_LIMIT = '0;

  typedef struct packed {
    status_e            status;
    logic               flushed;
    logic [PendW-1:0]   pending;
  } verdict_t;

  typedef struct packed {
    logic     cfg;
    int       nv;
    op_e      op;
    int       lit;
    logic     typed;
    verdict_t want;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OpW-1:0]         opcode_i = '0;
  logic signed [LitW-1:0] literal_i = '0;
  logic                   result_valid_o;
  logic [StatusW-1:0]     status_o;
  logic                   flushed_o;
  logic [PendW-1:0]       pending_cubes_o;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CfgAddrW-1:0]    paddr = '0;
  logic [CfgDataW-1:0]    pwdata = '0;
  logic [CfgDataW-1:0]    prdata;
  logic                   pready;

  bit_parallel_cube_clause_checker_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .literal_i       (literal_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .flushed_o       (flushed_o),
    .pending_cubes_o (pending_cubes_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow state of the checker
  logic [63:0]            lit_masks [0:2*MaxVarsDef];
  logic signed [LitW-1:0] clause_mem [0:StoreLitsDef-1];
  int unsigned            clause_len;
  int unsigned            cube_slot;
  logic [NumVarsW-1:0]    var_limit_q;

  verdict_t verdict_q[$];
  row_t     rows[$];
  bit       hidden_sign [1:CORE_VARS];
  bit       gaps_on;
  int       err_cnt;
  int       beats_sent;
  int       flush_cnt;
  int       fail_cnt;
  int       reject_cnt;
  int       cycle_cnt;
  verdict_t want;

  function automatic bit sweep_clauses();
    logic [63:0] used;
    logic [63:0] acc;
    bit          bad;
    used = (cube_slot >= SlotsDef) ? '1 : ((64'd1 << cube_slot) - 64'd1);
    acc = '0;
    bad = 1'b0;
    for (int i = 0; i < clause_len; i++) begin
      if (clause_mem[i] == 0) begin
        if (acc != used) bad = 1'b1;
        acc = '0;
      end else begin
        acc |= lit_masks[MaxVarsDef + int'(clause_mem[i])];
      end
    end
    for (int j = 0; j <= 2*MaxVarsDef; j++) lit_masks[j] = '0;
    cube_slot = 0;
    return bad;
  endfunction

  function automatic verdict_t step_checker(op_e op, logic signed [LitW-1:0] lit);
    verdict_t    v;
    int          lv;
    int unsigned mag;
    int unsigned bnd;
    logic [63:0] cur;
    v.status = STS_OK;
    v.flushed = 1'b0;
    lv = lit;
    mag = (lv < 0) ? -lv : lv;
    bnd = (var_limit_q < MaxVarsDef) ? var_limit_q : MaxVarsDef;
    case (op)
      OP_FORMULA: begin
        if (mag > bnd) v.status = STS_RANGE;
        else if (clause_len >= StoreLitsDef) v.status = STS_FULL;
        else begin
          clause_mem[clause_len] = lit;
          clause_len++;
        end
      end
      OP_CUBE: begin
        if (mag > bnd) v.status = STS_RANGE;
        else if (lv != 0) begin
          cur = 64'd1 << cube_slot;
          if ((lit_masks[MaxVarsDef - lv] & cur) != 0) v.status = STS_CONFLICT;
          else lit_masks[MaxVarsDef + lv] |= cur;
        end
      end
      OP_COMMIT: begin
        cube_slot++;
        if (cube_slot >= SlotsDef) begin
          if (sweep_clauses()) v.status = STS_FAIL;
          v.flushed = 1'b1;
        end
      end
      default: begin
        if (cube_slot != 0) begin
          if (sweep_clauses()) v.status = STS_FAIL;
          v.flushed = 1'b1;
        end
      end
    endcase
    v.pending = PendW'(cube_slot);
    return v;
  endfunction

  function automatic int rand_lit();
    return int'($urandom_range(0, 2*MaxVarsDef)) - MaxVarsDef;
  endfunction

  function automatic int extra_lit();
    int m;
    m = ($urandom_range(0, 1) == 1) ? $urandom_range(1, CORE_VARS)
                                     : $urandom_range(1, MaxVarsDef);
    return ($urandom_range(0, 1) == 1) ? -m : m;
  endfunction

  task automatic issue_beat(op_e op, int lit, bit typed, verdict_t given);
    verdict_t v;
    int       gap;
    opcode_i  <= op;
    literal_i <= lit[LitW-1:0];
    start     <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    v = step_checker(op, lit[LitW-1:0]);
    if (typed) v = given;
    verdict_q.insert(verdict_q.size(), v);
    beats_sent++;
    if (v.flushed) flush_cnt++;
    if (v.status == STS_FAIL) fail_cnt++;
    if (v.status inside {STS_RANGE, STS_FULL, STS_CONFLICT}) reject_cnt++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start     <= 1'b0;
      opcode_i  <= OpW'($urandom_range(0, 3));
      literal_i <= LitW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue(op_e op, int lit);
    issue_beat(op, lit, 1'b0, '0);
  endtask

  task automatic write_var_limit(int value);
    logic [CfgDataW-1:0] rd;
    start <= 1'b0;
    while (verdict_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    paddr   <= REG_VAR_LIMIT;
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[NumVarsW-1:0] !== value[NumVarsW-1:0]) begin
      err_cnt++;
      $error("var_limit: expected %0d, got %0d", value[NumVarsW-1:0], rd[NumVarsW-1:0]);
    end
    var_limit_q = value[NumVarsW-1:0];
  endtask

  task automatic add_row(bit cfg, int nv, op_e op, int lit, bit typed,
                         status_e st, bit fl, int pend);
    row_t r;
    r.cfg = cfg;
    r.nv = nv;
    r.op = op;
    r.lit = lit;
    r.typed = typed;
    r.want.status = st;
    r.want.flushed = fl;
    r.want.pending = PendW'(pend);
    rows.insert(rows.size(), r);
  endtask

  task automatic send_noise();
    op_e nop;
    int  l;
    nop = op_e'($urandom_range(0, 3));
    l = rand_lit();
    if (nop == OP_FORMULA && l == 0) l = 1;
    issue(nop, l);
  endtask

  // every clause holds one literal of the hidden assignment, so good cubes satisfy it
  task automatic send_clause();
    int lim;
    int v;
    int k;
    int pos;
    lim = (var_limit_q < CORE_VARS) ? var_limit_q : CORE_VARS;
    v = $urandom_range(1, lim);
    k = $urandom_range(0, 3);
    pos = $urandom_range(0, k);
    for (int i = 0; i <= k; i++) begin
      if (i == pos) issue(OP_FORMULA, hidden_sign[v] ? v : -v);
      else issue(OP_FORMULA, extra_lit());
    end
    issue(OP_FORMULA, 0);
  endtask

  task automatic send_cube(bit broken);
    int l;
    for (int v = 1; v <= CORE_VARS; v++) begin
      l = hidden_sign[v] ? v : -v;
      if (broken && $urandom_range(0, 7) == 0) l = -l;
      issue(OP_CUBE, l);
      if (broken && $urandom_range(0, 3) == 0) send_noise();
    end
    if ($urandom_range(0, 3) == 0) issue(OP_CUBE, extra_lit());
  endtask

  function automatic int pick_var_limit();
    case ($urandom_range(0, 4))
      0:       return 1;
      1:       return MaxVarsDef;
      2:       return $urandom_range(2, CORE_VARS - 1);
      default: return $urandom_range(CORE_VARS, MaxVarsDef);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $error("result beat with no expectation pending");
      end else begin
        want = verdict_q.pop_front();
        if (status_o !== want.status) begin
          err_cnt++;
          $error("status: expected %0d, got %0d", want.status, status_o);
        end
        if (flushed_o !== want.flushed) begin
          err_cnt++;
          $error("flushed: expected %0d, got %0d", want.flushed, flushed_o);
        end
        if (pending_cubes_o !== want.pending) begin
          err_cnt++;
          $error("pending_cubes: expected %0d, got %0d", want.pending, pending_cubes_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bit_parallel_cube_clause_checker_unit: mismatch");
      $finish;
    end
  end

  initial begin
    bit broken;
    int ncubes;
    int target;
    for (int j = 0; j <= 2*MaxVarsDef; j++) lit_masks[j] = '0;
    clause_len = 0;
    cube_slot = 0;
    var_limit_q = NumVarsRst;
    for (int v = 1; v <= CORE_VARS; v++) hidden_sign[v] = $urandom_range(0, 1);
    gaps_on = 1'b1;

    add_row(1, 1024, OP_FLUSH,      0,    1, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,    1024, 1, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,   -1024, 1, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,    1,    1, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,   -1,    1, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,    0,    1, STS_OK,       0, 0);
    add_row(0, 0,    OP_CUBE,       0,    1, STS_OK,       0, 0);
    add_row(0, 0,    OP_CUBE,       1024, 1, STS_OK,       0, 0);
    add_row(0, 0,    OP_CUBE,      -1024, 1, STS_CONFLICT, 0, 0);
    add_row(0, 0,    OP_CUBE,       1,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_COMMIT,     0,    1, STS_OK,       0, 1);
    // uncommitted literal in the open slot spoils the check
    add_row(0, 0,    OP_CUBE,      -1,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_FLUSH,      0,    0, STS_OK,       0, 0);
    add_row(1, 1,    OP_CUBE,       2,    1, STS_RANGE,    0, 0);
    add_row(0, 0,    OP_FORMULA,   -2,    1, STS_RANGE,    0, 0);
    // open clause left unchecked by the next flush
    add_row(0, 0,    OP_FORMULA,    1,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_CUBE,      -1,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_COMMIT,     0,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_FLUSH,      0,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,   -1,    0, STS_OK,       0, 0);
    add_row(0, 0,    OP_FORMULA,    0,    0, STS_OK,       0, 0);
    // empty cube committed: every clause fails
    add_row(1, 1024, OP_COMMIT,    -1,    1, STS_OK,       0, 1);
    add_row(0, 0,    OP_FLUSH,      1023, 1, STS_FAIL,     1, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cfg) write_var_limit(rows[i].nv);
      issue_beat(rows[i].op, rows[i].lit, rows[i].typed, rows[i].want);
    end

    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      broken = ($urandom_range(0, 2) == 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) write_var_limit(pick_var_limit());
      repeat ($urandom_range(0, 3)) send_clause();
      ncubes = ($urandom_range(0, 7) == 0) ? SlotsDef - cube_slot : $urandom_range(0, 6);
      repeat (ncubes) begin
        send_cube(broken);
        issue(OP_COMMIT, rand_lit());
      end
      if (broken && $urandom_range(0, 1) == 1) send_cube(broken);
      issue(OP_FLUSH, rand_lit());
    end

    // closing run with no random gaps: two empty clauses, then beats back to back
    gaps_on = 1'b0;
    write_var_limit(MaxVarsDef);
    issue(OP_FORMULA, 0);
    issue(OP_FORMULA, 0);
    repeat (3) issue(OP_FORMULA, extra_lit());
    send_cube(1'b0);
    issue(OP_COMMIT, rand_lit());
    send_cube(1'b0);
    issue(OP_FLUSH, rand_lit());
    write_var_limit(1);
    issue(OP_FORMULA, MaxVarsDef);
    issue(OP_FORMULA, 1);
    issue(OP_CUBE, 1);
    issue(OP_COMMIT, 0);
    issue(OP_FLUSH, 0);
    issue(OP_FLUSH, 0);

    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d beats sent, %0d clause sweeps, %0d failed sweeps, %0d rejected literals",
             beats_sent, flush_cnt, fail_cnt, reject_cnt);
    $display("clause store ended at %0d literals, %0d cycles", clause_len, cycle_cnt);
    if (err_cnt == 0) begin
      $display("bit_parallel_cube_clause_checker_unit: match");
    end else begin
      $display("bit_parallel_cube_clause_checker_unit: mismatch");
    end
    $finish;
  end

endmodule
